// ----- hdl/htins_pkg.sv -----
package htins_pkg;

  localparam int KEY_BYTES = 16;
  localparam int HASH_W = 32;
  localparam int SIZE_W = 11;
  localparam int SLOT_W = 10;
  localparam int TOTAL_W = 11;
  localparam int FIELD_W = 64;
  localparam logic [HASH_W-1:0] RS_MULT_A = 32'd63689;
  localparam logic [HASH_W-1:0] RS_MULT_B = 32'd378551;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } probe_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_HASH,
    H_MOD
  } home_state_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] key_high;
    logic [FIELD_W-1:0] key_low;
    logic [FIELD_W-1:0] text;
  } slot_word_t;

  // Multiplier used for key byte n: the running RS factor after n updates.
  function automatic logic [HASH_W-1:0] rs_coef(input int n);
    logic [HASH_W-1:0] a;
    a = RS_MULT_A;
    for (int i = 0; i < n; i++) begin
      a = a * RS_MULT_B;
    end
    return a;
  endfunction

  localparam logic [HASH_W-1:0] RS_COEF [KEY_BYTES] = '{
    rs_coef(0),  rs_coef(1),  rs_coef(2),  rs_coef(3),
    rs_coef(4),  rs_coef(5),  rs_coef(6),  rs_coef(7),
    rs_coef(8),  rs_coef(9),  rs_coef(10), rs_coef(11),
    rs_coef(12), rs_coef(13), rs_coef(14), rs_coef(15)
  };

endpackage

// ----- hdl/htins_ram.sv -----
module htins_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/htins_home.sv -----
module htins_home (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [htins_pkg::FIELD_W-1:0] key_high,
  input  logic [htins_pkg::FIELD_W-1:0] key_low,
  input  logic [htins_pkg::SIZE_W-1:0]  size,
  output logic                          done,
  output logic [htins_pkg::SIZE_W-1:0]  home
);

  localparam int STEP_W = $clog2(htins_pkg::HASH_W);
  localparam logic [STEP_W-1:0] HASH_LAST = STEP_W'(htins_pkg::KEY_BYTES - 1);
  localparam logic [STEP_W-1:0] MOD_LAST = STEP_W'(htins_pkg::HASH_W - 1);

  htins_pkg::home_state_t state, state_next;

  logic [2*htins_pkg::FIELD_W-1:0] key_sr;
  logic [htins_pkg::HASH_W-1:0]    h;
  logic [htins_pkg::SIZE_W-1:0]    rem, rem_next;
  logic [htins_pkg::SIZE_W:0]      trial;
  logic [STEP_W-1:0]               step;
  logic                            load, hash_en, mod_en;

  always_comb begin
    state_next = state;
    case (state)
      htins_pkg::H_IDLE: begin
        if (start) state_next = htins_pkg::H_HASH;
      end
      htins_pkg::H_HASH: begin
        if (step == HASH_LAST) state_next = htins_pkg::H_MOD;
      end
      htins_pkg::H_MOD: begin
        if (step == MOD_LAST) state_next = htins_pkg::H_IDLE;
      end
      default: state_next = htins_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    hash_en = 1'b0;
    mod_en  = 1'b0;
    case (state)
      htins_pkg::H_IDLE: load = start;
      htins_pkg::H_HASH: hash_en = 1'b1;
      htins_pkg::H_MOD:  mod_en = 1'b1;
      default: ;
    endcase
  end

  // One restoring remainder bit per cycle; the partial remainder stays below size.
  always_comb begin
    trial = {rem, h[htins_pkg::HASH_W-1]};
    if (trial >= {1'b0, size}) begin
      rem_next = htins_pkg::SIZE_W'(trial - {1'b0, size});
    end else begin
      rem_next = trial[htins_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htins_pkg::H_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= mod_en && (step == MOD_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_sr <= {key_high, key_low};
      h      <= '0;
      rem    <= '0;
      step   <= '0;
    end else if (hash_en) begin
      h <= h * htins_pkg::RS_COEF[step[3:0]]
           + {24'd0, key_sr[2*htins_pkg::FIELD_W-1 -: 8]};
      key_sr <= {key_sr[2*htins_pkg::FIELD_W-9:0], 8'd0};
      step   <= (step == HASH_LAST) ? '0 : step + 1'b1;
    end else if (mod_en) begin
      rem  <= rem_next;
      h    <= {h[htins_pkg::HASH_W-2:0], 1'b0};
      step <= step + 1'b1;
    end
  end

  assign home = rem;

endmodule

// ----- hdl/hash_table_insert_linear_probe.sv -----
// Insert into an open-addressed hash table with linear probing.
// Drive key_high, key_low and start_text with start high; the word is taken at
// a clock edge where start is high and busy is low. The key is hashed with the
// RS hash one byte per cycle, reduced modulo the table size one bit per
// cycle, and then the table is probed one slot per cycle. Each word gives one
// result: done is high for exactly one cycle with status, slot and entry_total
// valid. Busy stays high from accept to done and drops in the done cycle, so
// the next word can be accepted in that cycle and not before. The slot memory
// port, one read per cycle, sets the probe rate.
// The result cannot be held off; the receiver must take it in the done cycle.
// cfg_write loads table_size from cfg_data; write it only while busy is low.
// After rst the block sweeps the slot memory to clear every valid flag, one
// entry per cycle, with busy high. Reset also returns table_size to 1024 and
// the entry count to zero.
module hash_table_insert_linear_probe #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [htins_pkg::FIELD_W-1:0] key_high,
  input  logic [htins_pkg::FIELD_W-1:0] key_low,
  input  logic [htins_pkg::FIELD_W-1:0] start_text,
  input  logic                          cfg_write,
  input  logic [htins_pkg::SIZE_W-1:0]  cfg_data,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [htins_pkg::SLOT_W-1:0]  slot,
  output logic [htins_pkg::TOTAL_W-1:0] entry_total
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = $bits(htins_pkg::slot_word_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  htins_pkg::probe_state_t state, state_next;

  logic [htins_pkg::SIZE_W-1:0]  table_size;
  logic [htins_pkg::SIZE_W-1:0]  size_eff, size_q;
  logic [IDX_W-1:0]              clr;
  logic [CNT_W-1:0]              count, count_next;
  logic [31:0]                   count_wide;
  logic [htins_pkg::SIZE_W-1:0]  cur, cur_next, cur_inc;
  logic [htins_pkg::SIZE_W-1:0]  tries, tries_next, tries_inc;
  logic [htins_pkg::FIELD_W-1:0] kh, kl, txt;
  logic                          accept;
  logic                          home_done;
  logic [htins_pkg::SIZE_W-1:0]  home;
  logic                          probe_end;
  logic                          done_next;
  htins_pkg::status_t            status_next;
  logic [htins_pkg::SIZE_W-1:0]  slot_next;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  htins_pkg::slot_word_t         ram_wdata, ram_rdata;
  logic [WORD_W-1:0]             ram_rbits;

  assign busy   = (state != htins_pkg::S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (table_size == '0) begin
      size_eff = htins_pkg::SIZE_W'(1);
    end else if (32'(table_size) > 32'(TABLE_ENTRIES)) begin
      size_eff = htins_pkg::SIZE_W'(TABLE_ENTRIES);
    end else begin
      size_eff = table_size;
    end
  end

  htins_home u_home (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .key_high (key_high),
    .key_low  (key_low),
    .size     (size_q),
    .done     (home_done),
    .home     (home)
  );

  htins_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (IDX_W'(cur_next)),
    .rdata (ram_rbits)
  );

  assign ram_rdata = htins_pkg::slot_word_t'(ram_rbits);

  always_comb begin
    state_next = state;
    case (state)
      htins_pkg::S_CLEAR: begin
        if (clr == LAST_IDX) state_next = htins_pkg::S_IDLE;
      end
      htins_pkg::S_IDLE: begin
        if (start) state_next = htins_pkg::S_HASH;
      end
      htins_pkg::S_HASH: begin
        if (home_done) state_next = htins_pkg::S_PROBE;
      end
      htins_pkg::S_PROBE: begin
        if (probe_end) state_next = htins_pkg::S_IDLE;
      end
      default: state_next = htins_pkg::S_IDLE;
    endcase
  end

  // The read address follows the next probe position, so the registered read
  // data always belongs to the slot held in cur.
  always_comb begin
    cur_next    = cur;
    tries_next  = tries;
    count_next  = count;
    probe_end   = 1'b0;
    done_next   = 1'b0;
    status_next = htins_pkg::ST_FULL;
    slot_next   = '0;
    ram_we      = 1'b0;
    ram_waddr   = clr;
    ram_wdata   = '0;
    tries_inc   = tries + 1'b1;
    cur_inc     = cur + 1'b1;
    case (state)
      htins_pkg::S_CLEAR: begin
        ram_we = 1'b1;
      end
      htins_pkg::S_HASH: begin
        if (home_done) begin
          cur_next   = home;
          tries_next = '0;
        end
      end
      htins_pkg::S_PROBE: begin
        if (!ram_rdata.valid) begin
          probe_end   = 1'b1;
          done_next   = 1'b1;
          status_next = htins_pkg::ST_INSERTED;
          slot_next   = cur;
          count_next  = count + 1'b1;
          ram_we      = 1'b1;
          ram_waddr   = IDX_W'(cur);
          ram_wdata   = '{valid: 1'b1, key_high: kh, key_low: kl, text: txt};
        end else if (ram_rdata.key_high == kh && ram_rdata.key_low == kl) begin
          probe_end   = 1'b1;
          done_next   = 1'b1;
          status_next = htins_pkg::ST_PRESENT;
          slot_next   = cur;
        end else if (tries_inc == size_q) begin
          probe_end   = 1'b1;
          done_next   = 1'b1;
          status_next = htins_pkg::ST_FULL;
          slot_next   = '0;
        end else begin
          tries_next = tries_inc;
          cur_next   = (cur_inc == size_q) ? '0 : cur_inc;
        end
      end
      default: ;
    endcase
  end

  assign count_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= htins_pkg::S_CLEAR;
      clr        <= '0;
      count      <= '0;
      done       <= 1'b0;
      table_size <= htins_pkg::TABLE_SIZE_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (state == htins_pkg::S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (cfg_write) begin
        table_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    tries <= tries_next;
    if (accept) begin
      kh     <= key_high;
      kl     <= key_low;
      txt    <= start_text;
      size_q <= size_eff;
    end
    if (done_next) begin
      status      <= status_next;
      slot        <= slot_next[htins_pkg::SLOT_W-1:0];
      entry_total <= count_wide[htins_pkg::TOTAL_W-1:0];
    end
  end

endmodule
